// ===== rtl/core/ljpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared constants, widths and codes of the Lennard-Jones pair force pipeline.
// ----------------------------------------------------------------------------
package ljpf_pkg;

  // Number of active axes; coordinates of higher axes are ignored.
  localparam int unsigned DIMS = 3;
  localparam int unsigned AXES = 3;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned RES_W   = 64;

  localparam logic [RES_W-1:0] POS_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] NEG_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Digit-serial pipelined multiplier: A by one B digit per stage.
  localparam int unsigned MUL_AW    = 147;
  localparam int unsigned MUL_DW    = 8;
  localparam int unsigned MUL_STEPS = 9;
  localparam int unsigned MUL_BW    = MUL_DW * MUL_STEPS;
  localparam int unsigned MUL_PW    = MUL_AW + MUL_BW;

  // Restoring divider: one quotient bit per stage.
  localparam int unsigned DIV_RW    = 66;
  localparam int unsigned DIV_QW    = 64;
  localparam int unsigned DIV_STEPS = DIV_QW;

  typedef enum logic [0:0] {
    CFG_SIGMA      = 1'b0,
    CFG_WELL_DEPTH = 1'b1
  } cfg_reg_e;

endpackage

// ===== rtl/core/ljpf_mul.sv =====
// ----------------------------------------------------------------------------
// ljpf_mul
// Pipelined unsigned multiplier, one 8-bit digit of b per stage.
// ----------------------------------------------------------------------------
module ljpf_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ljpf_pkg::MUL_AW-1:0]   a_i,
  input  logic [ljpf_pkg::MUL_BW-1:0]   b_i,
  output logic [ljpf_pkg::MUL_PW-1:0]   p_o
);

  localparam int unsigned AW    = ljpf_pkg::MUL_AW;
  localparam int unsigned BW    = ljpf_pkg::MUL_BW;
  localparam int unsigned PW    = ljpf_pkg::MUL_PW;
  localparam int unsigned DW    = ljpf_pkg::MUL_DW;
  localparam int unsigned STEPS = ljpf_pkg::MUL_STEPS;

  logic [AW-1:0]    a_q   [STEPS-1];
  logic [BW-1:0]    b_q   [STEPS-1];
  logic [PW-1:0]    acc_q [STEPS];
  logic [PW-1:0]    acc_d [STEPS];
  logic [AW+DW-1:0] pp    [STEPS];

  always_comb begin
    pp[0]    = a_i * b_i[DW-1:0];
    acc_d[0] = PW'(pp[0]);
    for (int k = 1; k < STEPS; k++) begin
      pp[k]    = a_q[k-1] * b_q[k-1][k*DW +: DW];
      acc_d[k] = acc_q[k-1] + (PW'(pp[k]) << (k*DW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0] <= a_i;
      b_q[0] <= b_i;
      for (int k = 1; k < STEPS-1; k++) begin
        a_q[k] <= a_q[k-1];
        b_q[k] <= b_q[k-1];
      end
      acc_q <= acc_d;
    end
  end

  assign p_o = acc_q[STEPS-1];

endmodule

// ===== rtl/core/ljpf_div.sv =====
// ----------------------------------------------------------------------------
// ljpf_div
// Pipelined restoring divider, one quotient bit per stage. rem_i must be
// below den_i for the quotient to be exact.
// ----------------------------------------------------------------------------
module ljpf_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ljpf_pkg::DIV_RW-1:0]   rem_i,
  input  logic [ljpf_pkg::DIV_QW-1:0]   num_i,
  input  logic [ljpf_pkg::DIV_RW-1:0]   den_i,
  output logic [ljpf_pkg::DIV_QW-1:0]   quo_o
);

  localparam int unsigned RW    = ljpf_pkg::DIV_RW;
  localparam int unsigned QW    = ljpf_pkg::DIV_QW;
  localparam int unsigned STEPS = ljpf_pkg::DIV_STEPS;

  logic [RW-1:0] rem_q [STEPS-1];
  logic [RW-1:0] den_q [STEPS-1];
  logic [QW-1:0] nq_q  [STEPS];
  logic [RW-1:0] rem_d [STEPS-1];
  logic [QW-1:0] nq_d  [STEPS];
  logic [RW-1:0] rin   [STEPS];
  logic [RW-1:0] din   [STEPS];
  logic [QW-1:0] nin   [STEPS];
  logic [RW:0]   trial [STEPS];
  logic [RW:0]   diff  [STEPS];
  logic          ge    [STEPS];

  always_comb begin
    rin[0] = rem_i;
    din[0] = den_i;
    nin[0] = num_i;
    for (int k = 1; k < STEPS; k++) begin
      rin[k] = rem_q[k-1];
      din[k] = den_q[k-1];
      nin[k] = nq_q[k-1];
    end
    for (int k = 0; k < STEPS; k++) begin
      trial[k] = {rin[k], nin[k][QW-1]};
      diff[k]  = trial[k] - {1'b0, din[k]};
      ge[k]    = trial[k] >= {1'b0, din[k]};
      nq_d[k]  = {nin[k][QW-2:0], ge[k]};
    end
    for (int k = 0; k < STEPS-1; k++) begin
      rem_d[k] = ge[k] ? diff[k][RW-1:0] : trial[k][RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q <= nq_d;
      rem_q <= rem_d;
      den_q[0] <= den_i;
      for (int k = 1; k < STEPS-1; k++) begin
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign quo_o = nq_q[STEPS-1];

endmodule

// ===== rtl/core/lennard_jones_pair_force_unit.sv =====
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_unit
// Lennard-Jones 12-6 pair energy and gradient on the first particle.
// ----------------------------------------------------------------------------
// channel  | dir | width | contents (lowest bits first)
// s_axis   | in  | 192   | first_x/y/z, second_x/y/z, signed Q16.16
// m_axis   | out | 256+1 | pair_energy, grad_x/y/z Q32.32; tuser overlap
// cfg      | in  | 31    | idx 0 sigma, idx 1 well_depth, unsigned Q15.16
//
// One item per cycle sustained while the output is taken; the path from accept
// to output register runs two 64-stage divider chains, six 9-stage multipliers.
// The whole pipeline moves on one advance enable: it stalls only while the
// output register holds an item not yet taken.
// Reset clears valid bits and loads sigma = eps = 1.0; no clearing pass.
// Config is read live by later stages, so write it only while empty.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  ljpf_pkg::cfg_reg_e                  cfg_idx_i,
  input  logic [ljpf_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [6*ljpf_pkg::COORD_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pair_energy, grad_x, grad_y, grad_z
  output logic [4*ljpf_pkg::RES_W-1:0]        m_axis_tdata,
  // overlap
  output logic [0:0]                          m_axis_tuser
);

  localparam int unsigned CW    = ljpf_pkg::COORD_W;
  localparam int unsigned RW    = ljpf_pkg::RES_W;
  localparam int unsigned AXES  = ljpf_pkg::AXES;
  localparam int unsigned MSTEP = ljpf_pkg::MUL_STEPS;
  localparam int unsigned DSTEP = ljpf_pkg::DIV_STEPS;
  localparam int unsigned MAW   = ljpf_pkg::MUL_AW;
  localparam int unsigned MBW   = ljpf_pkg::MUL_BW;
  localparam int unsigned MPW   = ljpf_pkg::MUL_PW;
  localparam int unsigned DRW   = ljpf_pkg::DIV_RW;

  // stage positions along the side-band chain
  localparam int unsigned S_SQ   = MSTEP;           // squares ready
  localparam int unsigned S_R2   = S_SQ + 1;        // r2 held, q divide starts
  localparam int unsigned S_Q    = S_R2 + DSTEP;    // q ready, q*q starts
  localparam int unsigned S_Q2   = S_Q + MSTEP;     // q2 ready, q2*q starts
  localparam int unsigned S_LJ6  = S_Q2 + MSTEP;    // lj6 ready, lj6^2 starts
  localparam int unsigned S_LJ12 = S_LJ6 + MSTEP;   // lj12 ready
  localparam int unsigned S_MAG  = S_LJ12 + 1;      // differences held, eps muls
  localparam int unsigned S_EN   = S_MAG + MSTEP;   // energy, num*|dx| starts
  localparam int unsigned S_N    = S_EN + MSTEP;    // numerators, divides start
  localparam int unsigned S_G    = S_N + DSTEP;     // quotients ready
  localparam int unsigned S_OUT  = S_G + 1;         // output register

  typedef struct packed {
    logic [AXES-1:0][CW:0]  adx;
    logic [AXES-1:0]        dpos;
    logic [AXES-1:0]        dneg;
    logic [61:0]            sg2;
    logic [65:0]            r2;
    logic                   zero;
    logic                   huge;
    logic [44:0]            q;
    logic [70:0]            lj6;
    logic                   eneg;
    logic [109:0]           mag;
    logic                   tpos;
    logic [110:0]           tmag;
    logic [RW-1:0]          energy;
    logic                   eflag;
    logic [AXES-1:0]        ovf;
  } side_t;

  logic [ljpf_pkg::CFG_W-1:0] sigma_q, eps_q;
  logic [35:0]                eps24;

  logic                       adv;
  logic [S_OUT:0]             vld_q;
  side_t                      sb_q [S_OUT];
  side_t                      sb_d [S_OUT];
  side_t                      sf;

  logic signed [CW:0]         dx [AXES];

  logic [MPW-1:0]             sq_p [AXES];
  logic [MPW-1:0]             sg_p, m2_p, m3_p, m4_p, m5a_p, m5b_p;
  logic [MPW-1:0]             m6_p [AXES];
  logic [DRW-1:0]             r2_sum;
  logic [ljpf_pkg::DIV_QW-1:0] q_quo;
  logic [ljpf_pkg::DIV_QW-1:0] g_quo [AXES];

  logic [57:0]                q2;
  logic [70:0]                lj6;
  logic [109:0]               lj12;
  logic [110:0]               two12;
  logic [126:0]               em;
  logic [146:0]               num;
  logic [179:0]               nfull [AXES];
  logic [115:0]               nhi [AXES];

  logic [RW-1:0]              e_d, e_q;
  logic [AXES-1:0][RW-1:0]    g_d, g_q;
  logic                       ovl_d, ovl_q;
  logic                       flag;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= ljpf_pkg::CFG_W'(65536);
      eps_q   <= ljpf_pkg::CFG_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ljpf_pkg::CFG_SIGMA:      sigma_q <= cfg_data_i;
        ljpf_pkg::CFG_WELL_DEPTH: eps_q   <= cfg_data_i;
        default:                  sigma_q <= sigma_q;
      endcase
    end
  end

  assign eps24 = ({5'b0, eps_q} << 4) + ({5'b0, eps_q} << 3);

  // handshake: the whole pipe advances unless the output item is stuck
  assign adv           = !vld_q[S_OUT] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[S_OUT-1:0], s_axis_tvalid};
    end
  end

  // separation per axis
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (i < ljpf_pkg::DIMS) begin
        dx[i] = $signed({s_axis_tdata[i*CW+CW-1], s_axis_tdata[i*CW +: CW]})
              - $signed({s_axis_tdata[(i+3)*CW+CW-1], s_axis_tdata[(i+3)*CW +: CW]});
      end else begin
        dx[i] = '0;
      end
    end
  end

  // multipliers and dividers
  for (genvar i = 0; i < AXES; i++) begin : g_axis
    ljpf_mul u_sq (
      .clk_i (clk_i), .en_i (adv),
      .a_i   (MAW'(sb_q[0].adx[i])),
      .b_i   (MBW'(sb_q[0].adx[i])),
      .p_o   (sq_p[i])
    );
    ljpf_mul u_nd (
      .clk_i (clk_i), .en_i (adv),
      .a_i   (MAW'(num)),
      .b_i   (MBW'(sb_q[S_EN].adx[i])),
      .p_o   (m6_p[i])
    );
    assign nfull[i] = m6_p[i][179:0];
    assign nhi[i]   = nfull[i][179:64];
    ljpf_div u_gdiv (
      .clk_i (clk_i), .en_i (adv),
      .rem_i (nhi[i][DRW-1:0]),
      .num_i (nfull[i][63:0]),
      .den_i (sb_q[S_N].r2),
      .quo_o (g_quo[i])
    );
  end

  ljpf_mul u_sg (
    .clk_i (clk_i), .en_i (adv),
    .a_i (MAW'(sigma_q)), .b_i (MBW'(sigma_q)), .p_o (sg_p)
  );

  // q = sigma^2 * 2^32 / r2; exact whenever q is below the huge limit
  ljpf_div u_qdiv (
    .clk_i (clk_i), .en_i (adv),
    .rem_i (DRW'(sb_q[S_R2].sg2[61:32])),
    .num_i ({sb_q[S_R2].sg2[31:0], 32'b0}),
    .den_i (sb_q[S_R2].r2),
    .quo_o (q_quo)
  );

  ljpf_mul u_qq (
    .clk_i (clk_i), .en_i (adv),
    .a_i (MAW'(q_quo[44:0])), .b_i (MBW'(q_quo[44:0])), .p_o (m2_p)
  );
  assign q2 = m2_p[89:32];

  ljpf_mul u_q3 (
    .clk_i (clk_i), .en_i (adv),
    .a_i (MAW'(q2)), .b_i (MBW'(sb_q[S_Q2].q)), .p_o (m3_p)
  );
  assign lj6 = m3_p[102:32];

  ljpf_mul u_l12 (
    .clk_i (clk_i), .en_i (adv),
    .a_i (MAW'(lj6)), .b_i (MBW'(lj6)), .p_o (m4_p)
  );
  assign lj12  = m4_p[141:32];
  assign two12 = {lj12, 1'b0};

  ljpf_mul u_emul (
    .clk_i (clk_i), .en_i (adv),
    .a_i (MAW'(sb_q[S_MAG].mag)), .b_i (MBW'(eps_q)), .p_o (m5a_p)
  );
  ljpf_mul u_gmul (
    .clk_i (clk_i), .en_i (adv),
    .a_i (MAW'(sb_q[S_MAG].tmag)), .b_i (MBW'(eps24)), .p_o (m5b_p)
  );
  assign em  = m5a_p[140:14];
  assign num = m5b_p[146:0];

  assign r2_sum = sq_p[0][DRW-1:0] + sq_p[1][DRW-1:0] + sq_p[2][DRW-1:0];

  // side-band chain with per-stage updates
  always_comb begin
    sb_d[0] = '0;
    for (int i = 0; i < AXES; i++) begin
      sb_d[0].adx[i]  = dx[i][CW] ? (CW+1)'(-dx[i]) : (CW+1)'(dx[i]);
      sb_d[0].dneg[i] = dx[i][CW];
      sb_d[0].dpos[i] = !dx[i][CW] && (dx[i] != '0);
    end
    for (int k = 1; k < S_OUT; k++) begin
      sb_d[k] = sb_q[k-1];
    end

    sb_d[S_R2].r2  = r2_sum;
    sb_d[S_R2].sg2 = sg_p[61:0];

    sb_d[S_R2+1].zero = (sb_q[S_R2].r2 == '0);
    sb_d[S_R2+1].huge = (sb_q[S_R2].r2 == '0) ||
                        ({17'b0, sb_q[S_R2].sg2} >= {sb_q[S_R2].r2, 13'b0});

    sb_d[S_Q+1].q     = q_quo[44:0];
    sb_d[S_LJ6+1].lj6 = lj6;

    sb_d[S_MAG].eneg = lj12 < {39'b0, sb_q[S_LJ12].lj6};
    sb_d[S_MAG].mag  = (lj12 < {39'b0, sb_q[S_LJ12].lj6})
                     ? {39'b0, sb_q[S_LJ12].lj6} - lj12
                     : lj12 - {39'b0, sb_q[S_LJ12].lj6};
    sb_d[S_MAG].tpos = two12 >= {40'b0, sb_q[S_LJ12].lj6};
    sb_d[S_MAG].tmag = (two12 >= {40'b0, sb_q[S_LJ12].lj6})
                     ? two12 - {40'b0, sb_q[S_LJ12].lj6}
                     : {40'b0, sb_q[S_LJ12].lj6} - two12;

    // energy saturation
    if (sb_q[S_EN].eneg) begin
      if ((|em[126:64]) || (em[63] && (|em[62:0]))) begin
        sb_d[S_EN+1].energy = ljpf_pkg::NEG_MIN;
        sb_d[S_EN+1].eflag  = 1'b1;
      end else begin
        sb_d[S_EN+1].energy = RW'(0) - em[63:0];
        sb_d[S_EN+1].eflag  = 1'b0;
      end
    end else begin
      if (|em[126:63]) begin
        sb_d[S_EN+1].energy = ljpf_pkg::POS_MAX;
        sb_d[S_EN+1].eflag  = 1'b1;
      end else begin
        sb_d[S_EN+1].energy = em[63:0];
        sb_d[S_EN+1].eflag  = 1'b0;
      end
    end

    // quotient would need more than 64 bits
    for (int i = 0; i < AXES; i++) begin
      sb_d[S_N+1].ovf[i] = nhi[i] >= {50'b0, sb_q[S_N].r2};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q <= sb_d;
    end
  end

  // final saturation and overrides
  always_comb begin
    sf    = sb_q[S_G];
    e_d   = '0;
    g_d   = '0;
    flag  = 1'b0;
    if (sf.huge) begin
      if (sf.zero || (eps_q != '0)) begin
        e_d  = ljpf_pkg::POS_MAX;
        flag = 1'b1;
      end
      if (eps_q != '0) begin
        for (int i = 0; i < AXES; i++) begin
          if (sf.dpos[i]) begin
            g_d[i] = ljpf_pkg::NEG_MIN;
            flag   = 1'b1;
          end else if (sf.dneg[i]) begin
            g_d[i] = ljpf_pkg::POS_MAX;
            flag   = 1'b1;
          end
        end
      end
    end else begin
      e_d  = sf.energy;
      flag = sf.eflag;
      for (int i = 0; i < AXES; i++) begin
        if (sf.adx[i] != '0) begin
          if (sf.tpos == sf.dpos[i]) begin
            // negative result
            if (sf.ovf[i] || (g_quo[i][63] && (|g_quo[i][62:0]))) begin
              g_d[i] = ljpf_pkg::NEG_MIN;
              flag   = 1'b1;
            end else begin
              g_d[i] = RW'(0) - g_quo[i];
            end
          end else begin
            if (sf.ovf[i] || g_quo[i][63]) begin
              g_d[i] = ljpf_pkg::POS_MAX;
              flag   = 1'b1;
            end else begin
              g_d[i] = g_quo[i];
            end
          end
        end
      end
    end
    ovl_d = sf.zero || flag;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q   <= e_d;
      g_q   <= g_d;
      ovl_q <= ovl_d;
    end
  end

  assign m_axis_tvalid = vld_q[S_OUT];
  assign m_axis_tdata  = {g_q[2], g_q[1], g_q[0], e_q};
  assign m_axis_tuser  = ovl_q;

endmodule
